[rtl/core/substring_replace_stream_macros.svh]
// Assertion macros shared by the substring replace stream RTL.
// Expects signals named clk and rst in the including module's scope.
`ifndef SUBSTRING_REPLACE_STREAM_MACROS_SVH
`define SUBSTRING_REPLACE_STREAM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/srs_pkg.sv]
// Shared types and constants for the substring replace stream.
// No dependencies.
package srs_pkg;

  // Default window depth (bytes of search pattern supported)
  localparam int MAX_PATTERN_BYTES = 8;

  // Result queue: one replacement of up to 8 bytes, or a window flush
  localparam int OUT_SLOTS = 8;
  localparam int CNT_W     = $clog2(OUT_SLOTS + 1);

  // Register map, one 64-bit register every 8 bytes
  localparam int ADDR_W = 5;
  typedef enum logic [1:0] {
    REG_FIND_PATTERN    = 2'd0,
    REG_FIND_LENGTH     = 2'd1,
    REG_REPLACE_PATTERN = 2'd2,
    REG_REPLACE_LENGTH  = 2'd3
  } srs_reg_t;

  // Block of results produced by one accepted byte
  typedef struct packed {
    logic [OUT_SLOTS-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
    logic                      mark;   // single empty end marker
    logic                      last;   // final entry closes the text
  } srs_load_t;

endpackage

[rtl/core/srs_cell.sv]
// One byte cell of the match window shift chain.
// No dependencies.
module srs_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] din,
  input  logic [7:0] pat,
  output logic [7:0] q,
  output logic       eq
);

  // Compare the byte entering this position against its pattern byte
  assign eq = (din == pat);

  // Hand the byte down the chain on every accepted transfer
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

endmodule

[rtl/core/srs_outq.sv]
// Result shift queue: loads a block of results, shifts one out per transfer.
// Depends on srs_pkg.
module srs_outq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load_en,
  input  srs_pkg::srs_load_t       load,
  input  logic                     result_ready,
  output logic                     result_valid,
  output logic [7:0]               out_byte,
  output logic                     out_valid,
  output logic                     out_last,
  output logic                     can_load,
  output logic [srs_pkg::CNT_W-1:0] count_q
);

  logic [7:0] slot_q [srs_pkg::OUT_SLOTS];
  logic       mark_q;
  logic       last_q;
  logic       pop;

  assign result_valid = (count_q != '0);
  assign pop          = result_valid && result_ready;
  assign can_load     = (count_q == '0) ||
                        ((count_q == srs_pkg::CNT_W'(1)) && result_ready);

  // Head of the queue drives the result fields
  assign out_byte  = mark_q ? 8'h00 : slot_q[0];
  assign out_valid = !mark_q;
  assign out_last  = last_q && (count_q == srs_pkg::CNT_W'(1));

  // Control: entry count and block flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count_q <= '0;
      mark_q  <= 1'b0;
      last_q  <= 1'b0;
    end else if (load_en) begin
      count_q <= load.count;
      mark_q  <= load.mark;
      last_q  <= load.last;
    end else if (pop) begin
      count_q <= count_q - srs_pkg::CNT_W'(1);
    end
  end

  // Payload slots shift toward the head
  always_ff @(posedge clk) begin
    for (int j = 0; j < srs_pkg::OUT_SLOTS; j++) begin
      if (load_en) begin
        slot_q[j] <= load.bytes[j];
      end else if (pop) begin
        slot_q[j] <= (j == srs_pkg::OUT_SLOTS - 1) ? 8'h00 : slot_q[(j + 1) % srs_pkg::OUT_SLOTS];
      end
    end
  end

endmodule

[rtl/core/substring_replace_stream.sv]
// Top level of the streaming substring find-and-replace block.
// Depends on srs_pkg, srs_cell, srs_outq and substring_replace_stream_macros.svh.
//
// Bytes enter on the in_valid/in_ready channel with a last flag; every
// leftmost, non-overlapping occurrence of find_pattern (find_length bytes,
// 1 to MAX_PATTERN_BYTES) is replaced by replace_length bytes of
// replace_pattern, all else passes through in order. The window is a chain of
// byte cells that shifts on each accepted byte; the results of one byte are
// loaded as a block into an 8-slot result queue that shifts out one result
// per cycle while result_ready is high. A byte is accepted when the queue is
// empty or its final result leaves in the same cycle, so no new byte is taken
// while more than one result of the previous byte is still queued. The final
// byte of a text flushes the window; if it yields nothing, one result with
// out_valid low and out_last high is sent.
// Registers (64-bit, byte address 8*i): find_pattern, find_length,
// replace_pattern, replace_length; write them only while the block is idle.
`include "substring_replace_stream_macros.svh"

module substring_replace_stream #(
  parameter int MAX_PATTERN_BYTES = srs_pkg::MAX_PATTERN_BYTES
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [srs_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_byte,
  input  logic                      in_last,
  // result channel
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [7:0]                out_byte,
  output logic                      out_valid,
  output logic                      out_last
);

  localparam int N      = MAX_PATTERN_BYTES;
  localparam int FILL_W = $clog2(N + 1);

  // Configuration registers
  logic [63:0] find_pattern;
  logic [3:0]  find_length;
  logic [63:0] replace_pattern;
  logic [3:0]  replace_length;

  // Window control
  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] fill_next;
  logic [FILL_W-1:0] fill_p;
  logic [FILL_W-1:0] act_len;
  logic [3:0]        act_rlen;
  logic              full;
  logic              hit;
  logic              accept;
  logic              cfg_wr;
  srs_pkg::srs_reg_t reg_sel;

  // Cell chain
  logic [7:0] cell_din [N];
  logic [7:0] cell_q   [N];
  logic [7:0] pat_sel  [N];
  logic [N-1:0] cell_eq;

  // Result queue
  srs_pkg::srs_load_t         load;
  logic                       can_load;
  logic [srs_pkg::CNT_W-1:0]  q_count;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign reg_sel  = srs_pkg::srs_reg_t'(paddr[4:3]);
  assign in_ready = can_load;
  assign accept   = in_valid && in_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      find_pattern    <= '0;
      find_length     <= 4'd1;
      replace_pattern <= '0;
      replace_length  <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        srs_pkg::REG_FIND_PATTERN:    find_pattern    <= pwdata;
        srs_pkg::REG_FIND_LENGTH:     find_length     <= pwdata[3:0];
        srs_pkg::REG_REPLACE_PATTERN: replace_pattern <= pwdata;
        srs_pkg::REG_REPLACE_LENGTH:  replace_length  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_sel)
      srs_pkg::REG_FIND_PATTERN:    prdata = find_pattern;
      srs_pkg::REG_FIND_LENGTH:     prdata = {60'd0, find_length};
      srs_pkg::REG_REPLACE_PATTERN: prdata = replace_pattern;
      srs_pkg::REG_REPLACE_LENGTH:  prdata = {60'd0, replace_length};
      default:                      prdata = '0;
    endcase
  end

  // Effective lengths: find clamped to 1..N, replace to 0..8
  always_comb begin
    if (find_length == 4'd0) begin
      act_len = FILL_W'(1);
    end else if (32'(find_length) > N) begin
      act_len = FILL_W'(N);
    end else begin
      act_len = FILL_W'(find_length);
    end
    act_rlen = (replace_length > 4'd8) ? 4'd8 : replace_length;
  end

  // Pattern byte seen by each cell: cell k holds the byte k steps old
  always_comb begin
    for (int k = 0; k < N; k++) begin
      pat_sel[k] = 8'h00;
      for (int m = 0; m < 8; m++) begin
        if (int'(act_len) - 1 - k == m) begin
          pat_sel[k] = find_pattern[8*m +: 8];
        end
      end
    end
  end

  // Window cells, newest byte enters cell 0
  for (genvar k = 0; k < N; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_din[k] = in_byte;
    end else begin : g_body
      assign cell_din[k] = cell_q[k-1];
    end
    srs_cell u_cell (
      .clk   (clk),
      .shift (accept),
      .din   (cell_din[k]),
      .pat   (pat_sel[k]),
      .q     (cell_q[k]),
      .eq    (cell_eq[k])
    );
  end

  // Match detect over the cells inside the active length
  always_comb begin
    fill_p = fill_q + FILL_W'(1);
    full   = (fill_p == act_len);
    hit    = full;
    for (int k = 0; k < N; k++) begin
      if (k < int'(act_len) && !cell_eq[k]) begin
        hit = 1'b0;
      end
    end
  end

  // Result block for the accepted byte
  always_comb begin
    load = '0;
    for (int j = 0; j < srs_pkg::OUT_SLOTS; j++) begin
      if (hit) begin
        load.bytes[j] = replace_pattern[8*j +: 8];
      end else begin
        for (int k = 0; k < N; k++) begin
          if (int'(fill_p) - 1 - j == k) begin
            load.bytes[j] = cell_din[k];
          end
        end
      end
    end
    if (hit) begin
      load.count = srs_pkg::CNT_W'(act_rlen);
    end else if (in_last) begin
      load.count = srs_pkg::CNT_W'(fill_p);
    end else if (full) begin
      load.count = srs_pkg::CNT_W'(1);
    end
    // empty end marker when the final byte yields nothing
    if (in_last && load.count == '0) begin
      load.count = srs_pkg::CNT_W'(1);
      load.mark  = 1'b1;
    end
    load.last = in_last;
  end

  // Window fill count
  always_comb begin
    fill_next = fill_q;
    if (cfg_wr && reg_sel == srs_pkg::REG_FIND_LENGTH) begin
      fill_next = '0;
    end else if (accept) begin
      if (hit || in_last) begin
        fill_next = '0;
      end else if (full) begin
        fill_next = fill_q;
      end else begin
        fill_next = fill_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_next;
    end
  end

  srs_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .load_en      (accept),
    .load         (load),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .out_last     (out_last),
    .can_load     (can_load),
    .count_q      (q_count)
  );

  // Checks
  `SRS_ASSERT_NOW(a_fill_bound, 1'b1, fill_q < act_len, "window fill reached pattern length")
  `SRS_ASSERT_NOW(a_marker_last, result_valid && !out_valid, out_last, "end marker not last")
  `SRS_ASSERT_NEXT(a_last_flush, accept && in_last, fill_q == '0 && q_count != '0, "final byte did not flush")

endmodule
